// ===== hdl/quad_cell_tip_tilt_corrector_macros.svh =====
// assertion macros for the quad-cell tip/tilt corrector
`ifndef QUAD_CELL_TIP_TILT_CORRECTOR_MACROS_SVH
`define QUAD_CELL_TIP_TILT_CORRECTOR_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication under an active-low reset
`define QCTT_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication under an active-low reset
`define QCTT_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`else

`define QCTT_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg)
`define QCTT_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)

`endif

`endif

// ===== hdl/qctt_pkg.sv =====
// types, constants and helper functions of the quad-cell tip/tilt corrector
package qctt_pkg;

    // parameter defaults
    localparam int ADC_BITS_DEF    = 16;
    localparam int MAX_SAMPLES_DEF = 255;

    // field and register widths
    localparam int CELL_W         = 16;
    localparam int NUM_CELLS      = 4;
    localparam int IN_DATA_W      = NUM_CELLS * CELL_W;
    localparam int IN_USER_W      = 3;
    localparam int SAMPLE_COUNT_W = 8;
    localparam int GAIN_W         = 16;
    localparam int THRESH_W       = 15;
    localparam int ERR_W          = 16;
    localparam int STEP_W         = 19;
    localparam int OUTCOME_W      = 3;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 16;

    // result packing
    localparam int OUT_FIELDS_W = 2 + 2 * ERR_W + 3 * STEP_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // divider: one integer step then fifteen fraction steps
    localparam int DIV_STEPS = ERR_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // shared multiplier and step arithmetic
    localparam int MUL_A_W  = 33;
    localparam int MUL_B_W  = 25;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 60;
    localparam int TIP_K    = 15134891;
    localparam int TILT_K   = 300;
    localparam int TILT_SH  = 16;
    localparam int ROUND_SH = 39;

    localparam logic [ACC_W-1:0]        ISSUE_LIM     = ACC_W'(3) << ROUND_SH;
    localparam logic signed [ERR_W-1:0] ON_TARGET_LIM = 16'sd1638;
    localparam logic signed [ERR_W-1:0] ERR_MAX       = 16'sh7fff;

    // register reset values
    localparam logic [SAMPLE_COUNT_W-1:0] SAMPLE_COUNT_RST = 8'd5;
    localparam logic [GAIN_W-1:0]         LOOP_GAIN_RST    = 16'd256;
    localparam logic [THRESH_W-1:0]       THRESH_RST       = 15'd164;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SAMPLE_COUNT  = 3'd0,
        CFG_LOOP_GAIN     = 3'd1,
        CFG_THRESHOLD     = 3'd2,
        CFG_TILT_PARITY   = 3'd3,
        CFG_TIP_PARITY    = 3'd4
    } cfg_index_t;

    // result kinds
    typedef enum logic [OUTCOME_W-1:0] {
        OUT_ACCUM = 3'd0,
        OUT_OPEN  = 3'd1,
        OUT_LOW   = 3'd2,
        OUT_HOLD  = 3'd3,
        OUT_STEP  = 3'd4
    } outcome_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROC,
        ST_DIV,
        ST_MUL,
        ST_COMB,
        ST_SUM,
        ST_RND,
        ST_FIN
    } state_t;

    // magnitude of a step accumulator
    function automatic logic [ACC_W-1:0] abs_acc(input logic signed [ACC_W-1:0] x);
        return x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
    endfunction

    // round to whole tenths, halves away from zero
    function automatic logic signed [STEP_W-1:0] round_step(
        input logic signed [ACC_W-1:0] x
    );
        logic [ACC_W-1:0]         m;
        logic [ACC_W-1:0]         r;
        logic signed [STEP_W-1:0] rs;
        m  = abs_acc(x);
        r  = (m + (ACC_W'(1) << (ROUND_SH - 1))) >> ROUND_SH;
        rs = STEP_W'(r);
        return x[ACC_W-1] ? -rs : rs;
    endfunction

endpackage

// ===== hdl/quad_cell_tip_tilt_corrector.sv =====
// quad-cell tip/tilt corrector: accumulation, serial normalisation, step derivation
// A readout that only accumulates passes PROC then FIN; an evaluation adds two 16-step
// restoring divisions and, in closed loop above threshold, four passes of the shared
// multiplier and the COMB, SUM and RND states. One readout at a time: the next is accepted
// once the previous result is in the output register, and FIN waits while that is held.
// Reset (aresetn low, synchronous) clears sums, count, flags and errors; config takes defaults.
`include "quad_cell_tip_tilt_corrector_macros.svh"

module quad_cell_tip_tilt_corrector
    import qctt_pkg::*;
#(
    parameter int ADC_BITS    = ADC_BITS_DEF,
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    // readout requests
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // cell_bottom_left, cell_bottom_right, cell_top_right, cell_top_left
    input  logic [IN_DATA_W-1:0]   s_tdata,
    // read_ok, laser_on, loop_closed_request
    input  logic [IN_USER_W-1:0]   s_tuser,
    // results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // signal_good, on_target, tilt_error, tip_error, step_a, step_b, step_c, zero pad
    output logic [OUT_DATA_W-1:0]  m_tdata,
    // outcome
    output logic [OUTCOME_W-1:0]   m_tuser
);

    localparam int CELL_SW = (ADC_BITS > CELL_W) ? CELL_W + 1 : ADC_BITS;
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W   = CELL_SW - 1 + CNT_W;
    localparam int TOT_W   = SUM_W + 2;
    localparam int TGT_W   = (CNT_W > SAMPLE_COUNT_W) ? CNT_W : SAMPLE_COUNT_W;
    localparam int CMP_W   = CELL_SW + THRESH_W + 1;

    state_t state_reg, state_next;

    // configuration registers
    logic [SAMPLE_COUNT_W-1:0] sample_count_reg;
    logic [GAIN_W-1:0]         loop_gain_reg;
    logic [THRESH_W-1:0]       thresh_reg;
    logic                      tilt_par_reg;
    logic                      tip_par_reg;

    // persistent block state
    logic [SUM_W-1:0]        sum_reg [NUM_CELLS];
    logic [CNT_W-1:0]        count_reg;
    logic                    prev_mode_reg;
    logic                    sg_reg;
    logic                    ot_reg;
    logic signed [ERR_W-1:0] err_reg [2];

    // current readout
    logic signed [CELL_SW-1:0] cell_in  [NUM_CELLS];
    logic signed [CELL_SW-1:0] cell_reg [NUM_CELLS];
    logic                      laser_reg;
    logic                      closed_reg;

    // evaluation working registers
    logic                    below_reg;
    logic [TOT_W-1:0]        total_reg;
    logic [TOT_W-1:0]        mag_reg [2];
    logic                    neg_reg [2];
    logic [TOT_W-1:0]        rem_reg;
    logic [ERR_W-1:0]        quo_reg;
    logic [DIV_CNT_W-1:0]    div_cnt_reg;
    logic                    div_sel_reg;
    logic [1:0]              mul_cnt_reg;
    logic signed [MUL_A_W-1:0] p_reg    [2];
    logic signed [ACC_W-1:0]   corr_reg [2];
    logic signed [ACC_W-1:0]   acc_reg  [3];
    logic [ACC_W-1:0]          abs_ab_reg;
    outcome_t                  res_outcome_reg;
    logic signed [STEP_W-1:0]  res_step_reg [3];

    // output register
    logic                     m_valid_reg;
    outcome_t                 m_outcome_reg;
    logic                     m_sg_reg;
    logic                     m_ot_reg;
    logic signed [ERR_W-1:0]  m_tilt_reg;
    logic signed [ERR_W-1:0]  m_tip_reg;
    logic signed [STEP_W-1:0] m_step_reg [3];

    logic s_accept;
    logic out_free;

    // readout decoding: two's complement in ADC_BITS, zero on read failure
    always_comb begin
        for (int i = 0; i < NUM_CELLS; i++) begin
            cell_in[i] = s_tuser[0] ? CELL_SW'(s_tdata[i*CELL_W +: CELL_W]) : '0;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // per-readout decision
    logic                      mode_change;
    logic [TGT_W-1:0]          target_fix;
    logic [TGT_W-1:0]          target;
    logic [CNT_W-1:0]          count_eff;
    logic                      evaluate;
    logic                      all_pos;
    logic                      below;
    logic signed [CMP_W-1:0]   th_cmp;
    logic signed [CMP_W-1:0]   c_cmp [NUM_CELLS];

    always_comb begin
        mode_change = (prev_mode_reg != closed_reg);
        target_fix  = (sample_count_reg == '0) ? TGT_W'(1) : TGT_W'(sample_count_reg);
        target      = (target_fix > TGT_W'(MAX_SAMPLES)) ? TGT_W'(MAX_SAMPLES) : target_fix;
        count_eff   = mode_change ? '0 : count_reg;
        evaluate    = (TGT_W'(count_eff) >= target);
        th_cmp      = CMP_W'($signed({1'b0, thresh_reg}));
        all_pos     = 1'b1;
        below       = 1'b1;
        for (int i = 0; i < NUM_CELLS; i++) begin
            c_cmp[i] = CMP_W'(cell_reg[i]);
            if (cell_reg[i][CELL_SW-1] || (cell_reg[i] == '0)) all_pos = 1'b0;
            if (c_cmp[i] >= th_cmp) below = 1'b0;
        end
    end

    // total and differences of the cell sums
    logic [TOT_W-1:0]        pair_r, pair_l, pair_t, pair_b, total_sum;
    logic signed [TOT_W:0]   tilt_d, tip_d;

    always_comb begin
        pair_r    = TOT_W'(sum_reg[1]) + TOT_W'(sum_reg[2]);
        pair_l    = TOT_W'(sum_reg[0]) + TOT_W'(sum_reg[3]);
        pair_t    = TOT_W'(sum_reg[2]) + TOT_W'(sum_reg[3]);
        pair_b    = TOT_W'(sum_reg[0]) + TOT_W'(sum_reg[1]);
        total_sum = pair_r + pair_l;
        tilt_d    = $signed({1'b0, pair_r}) - $signed({1'b0, pair_l});
        tip_d     = $signed({1'b0, pair_t}) - $signed({1'b0, pair_b});
    end

    // shared compare/subtract unit: one quotient bit per cycle
    logic [TOT_W:0]          trial;
    logic [TOT_W:0]          trial_sub;
    logic                    ge;
    logic [TOT_W-1:0]        rem_new;
    logic [ERR_W-1:0]        quo_new;
    logic signed [ERR_W-1:0] err_new;
    logic                    div_last;
    logic                    on_tgt;

    always_comb begin
        trial     = (div_cnt_reg == '0) ? {1'b0, mag_reg[div_sel_reg]} : {rem_reg, 1'b0};
        trial_sub = trial - {1'b0, total_reg};
        ge        = (trial >= {1'b0, total_reg});
        rem_new   = ge ? trial_sub[TOT_W-1:0] : trial[TOT_W-1:0];
        quo_new   = {quo_reg[ERR_W-2:0], ge};
        if (total_reg == '0) begin
            err_new = '0;
        end else if (neg_reg[div_sel_reg]) begin
            err_new = -$signed(quo_new);
        end else if (quo_new[ERR_W-1]) begin
            err_new = ERR_MAX;
        end else begin
            err_new = $signed(quo_new);
        end
        div_last = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
        on_tgt   = (err_reg[0] <= ON_TARGET_LIM) && (err_reg[0] >= -ON_TARGET_LIM) &&
                   (err_new <= ON_TARGET_LIM) && (err_new >= -ON_TARGET_LIM);
    end

    // shared multiplier: tip*gain, tilt*gain, then the two correction scales
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    always_comb begin
        mul_a = mul_cnt_reg[1] ? p_reg[~mul_cnt_reg[0]] : MUL_A_W'(err_reg[~mul_cnt_reg[0]]);
        if (!mul_cnt_reg[1]) begin
            mul_b = MUL_B_W'(loop_gain_reg);
        end else if (mul_cnt_reg[0]) begin
            mul_b = MUL_B_W'(TILT_K);
        end else begin
            mul_b = MUL_B_W'(TIP_K);
        end
        prod = mul_a * mul_b;
    end

    // parity-signed terms of the three actuator steps
    logic signed [ACC_W-1:0] ntip, ttl;
    logic [ACC_W-1:0]        abs_all;
    logic                    issue;

    always_comb begin
        ntip    = tip_par_reg ? -corr_reg[1] : corr_reg[1];
        ttl     = tilt_par_reg ? corr_reg[0] : -corr_reg[0];
        abs_all = abs_ab_reg + abs_acc(acc_reg[2]);
        issue   = (abs_all > ISSUE_LIM);
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_accept) state_next = ST_PROC;
            ST_PROC: state_next = evaluate ? ST_DIV : ST_FIN;
            ST_DIV: begin
                if (div_last && div_sel_reg) begin
                    state_next = (!closed_reg || below_reg) ? ST_FIN : ST_MUL;
                end
            end
            ST_MUL:  if (mul_cnt_reg == 2'd3) state_next = ST_COMB;
            ST_COMB: state_next = ST_SUM;
            ST_SUM:  state_next = ST_RND;
            ST_RND:  state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
        endcase
    end

    // configuration registers and persistent state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= SAMPLE_COUNT_RST;
            loop_gain_reg    <= LOOP_GAIN_RST;
            thresh_reg       <= THRESH_RST;
            tilt_par_reg     <= 1'b0;
            tip_par_reg      <= 1'b1;
            for (int i = 0; i < NUM_CELLS; i++) sum_reg[i] <= '0;
            count_reg     <= '0;
            prev_mode_reg <= 1'b0;
            sg_reg        <= 1'b0;
            ot_reg        <= 1'b0;
            err_reg[0]    <= '0;
            err_reg[1]    <= '0;
        end else begin
            // register writes
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_SAMPLE_COUNT: sample_count_reg <= cfg_wr_data[SAMPLE_COUNT_W-1:0];
                    CFG_LOOP_GAIN:    loop_gain_reg    <= cfg_wr_data[GAIN_W-1:0];
                    CFG_THRESHOLD:    thresh_reg       <= cfg_wr_data[THRESH_W-1:0];
                    CFG_TILT_PARITY:  tilt_par_reg     <= cfg_wr_data[0];
                    CFG_TIP_PARITY:   tip_par_reg      <= cfg_wr_data[0];
                    default: ;
                endcase
            end
            // flags, mode change and accumulation
            if (state_reg == ST_PROC) begin
                sg_reg        <= laser_reg && sg_reg;
                ot_reg        <= laser_reg && ot_reg && !mode_change;
                prev_mode_reg <= closed_reg;
                if (evaluate) begin
                    for (int i = 0; i < NUM_CELLS; i++) sum_reg[i] <= '0;
                    count_reg <= '0;
                end else if (all_pos) begin
                    for (int i = 0; i < NUM_CELLS; i++) begin
                        sum_reg[i] <= (mode_change ? '0 : sum_reg[i]) +
                                      SUM_W'(cell_reg[i][CELL_SW-2:0]);
                    end
                    count_reg <= count_eff + CNT_W'(1);
                end else begin
                    if (mode_change) begin
                        for (int i = 0; i < NUM_CELLS; i++) sum_reg[i] <= '0;
                    end
                    count_reg <= count_eff;
                end
            end
            // normalised errors and evaluation flags
            if ((state_reg == ST_DIV) && div_last) begin
                err_reg[div_sel_reg] <= err_new;
                if (div_sel_reg) begin
                    if (!closed_reg) begin
                        ot_reg <= 1'b0;
                    end else if (below_reg) begin
                        sg_reg <= 1'b0;
                        ot_reg <= 1'b0;
                    end else begin
                        sg_reg <= 1'b1;
                        ot_reg <= on_tgt;
                    end
                end
            end
        end
    end

    // sequencer counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
            div_sel_reg <= 1'b0;
            mul_cnt_reg <= '0;
        end else begin
            priority case (state_reg)
                ST_PROC: begin
                    div_cnt_reg <= '0;
                    div_sel_reg <= 1'b0;
                    mul_cnt_reg <= '0;
                end
                ST_DIV: begin
                    div_cnt_reg <= div_last ? '0 : div_cnt_reg + DIV_CNT_W'(1);
                    if (div_last) div_sel_reg <= 1'b1;
                end
                ST_MUL:  mul_cnt_reg <= mul_cnt_reg + 2'd1;
                default: ;
            endcase
        end
    end

    // working datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    for (int i = 0; i < NUM_CELLS; i++) cell_reg[i] <= cell_in[i];
                    laser_reg  <= s_tuser[1];
                    closed_reg <= s_tuser[2];
                end
            end
            ST_PROC: begin
                below_reg  <= below;
                total_reg  <= total_sum;
                neg_reg[0] <= tilt_d[TOT_W];
                neg_reg[1] <= tip_d[TOT_W];
                mag_reg[0] <= tilt_d[TOT_W] ? TOT_W'(-tilt_d) : TOT_W'(tilt_d);
                mag_reg[1] <= tip_d[TOT_W] ? TOT_W'(-tip_d) : TOT_W'(tip_d);
                res_outcome_reg <= OUT_ACCUM;
                for (int i = 0; i < 3; i++) res_step_reg[i] <= '0;
            end
            ST_DIV: begin
                rem_reg <= rem_new;
                quo_reg <= quo_new;
                if (div_last && div_sel_reg) begin
                    if (!closed_reg) begin
                        res_outcome_reg <= OUT_OPEN;
                    end else if (below_reg) begin
                        res_outcome_reg <= OUT_LOW;
                    end
                end
            end
            ST_MUL: begin
                if (!mul_cnt_reg[1]) begin
                    p_reg[~mul_cnt_reg[0]] <= MUL_A_W'(prod);
                end else if (mul_cnt_reg[0]) begin
                    corr_reg[0] <= ACC_W'(prod) <<< TILT_SH;
                end else begin
                    corr_reg[1] <= ACC_W'(prod);
                end
            end
            ST_COMB: begin
                acc_reg[0] <= -(ntip <<< 1);
                acc_reg[1] <= ntip + ttl;
                acc_reg[2] <= ntip - ttl;
            end
            ST_SUM: abs_ab_reg <= abs_acc(acc_reg[0]) + abs_acc(acc_reg[1]);
            ST_RND: begin
                if (issue) begin
                    res_outcome_reg <= OUT_STEP;
                    for (int i = 0; i < 3; i++) res_step_reg[i] <= round_step(acc_reg[i]);
                end else begin
                    res_outcome_reg <= OUT_HOLD;
                end
            end
            ST_FIN: ;
        endcase
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_FIN) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_FIN) && out_free) begin
            m_outcome_reg <= res_outcome_reg;
            m_sg_reg      <= sg_reg;
            m_ot_reg      <= ot_reg;
            m_tilt_reg    <= err_reg[0];
            m_tip_reg     <= err_reg[1];
            for (int i = 0; i < 3; i++) m_step_reg[i] <= res_step_reg[i];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_outcome_reg;
    assign m_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), m_step_reg[2], m_step_reg[1],
                       m_step_reg[0], m_tip_reg, m_tilt_reg, m_ot_reg, m_sg_reg};

    // checks
    `QCTT_ASSERT_NEXT(a_accept_to_proc, aclk, aresetn, s_accept, state_reg == ST_PROC, "accepted readout not processed")
    `QCTT_ASSERT_IMPLY(a_rem_bound, aclk, aresetn, (state_reg == ST_DIV) && (div_cnt_reg != '0) && (total_reg != '0), rem_reg < total_reg, "divider remainder not below divisor")
    `QCTT_ASSERT_IMPLY(a_steps_only_issued, aclk, aresetn, m_valid_reg && (m_outcome_reg != OUT_STEP), (m_step_reg[0] == '0) && (m_step_reg[1] == '0) && (m_step_reg[2] == '0), "step without issue outcome")
    `QCTT_ASSERT_IMPLY(a_target_needs_signal, aclk, aresetn, m_valid_reg && m_ot_reg, m_sg_reg, "on target without good signal")

endmodule
